// ----- hdl/mmt_pkg.sv -----
// Shared types and constants for the multiset mex tracker.
// Used by mmt_ctrl, mmt_datapath and multiset_mex_tracker; no dependencies.
`default_nettype none

package mmt_pkg;

    localparam int VALUE_W             = 16;
    localparam int COUNT_W             = 16;
    localparam int MEX_W               = 11;
    localparam int LIMIT_W             = 10;
    localparam int VALUE_SLOTS_DEFAULT = 1024;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1023;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear;      // write zero at the sweep address and advance it
        logic load_item;  // capture an accepted input beat
        logic update;     // apply the item to its count and to the mex
        logic scan_rd;    // read the count at the mex
        logic scan_step;  // advance the mex by one
        logic load_out;   // move the result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;    // sweep is at the last slot
        logic scan_start;    // item is an in-range insert at the mex
        logic mex_in_bound;  // mex is not above the limit in use
        logic scan_hit;      // count read at the mex is nonzero
        logic out_free;      // output register can take a result this cycle
    } t_status;

endpackage

`default_nettype wire

// ----- hdl/mmt_ctrl.sv -----
// Sequencing state machine for the multiset mex tracker.
// Depends on mmt_pkg for the state, command and status types.
`default_nettype none

module mmt_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  mmt_pkg::t_status  i_status,
    output mmt_pkg::t_cmd     o_cmd
);

    mmt_pkg::t_state r_state;
    mmt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mmt_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            mmt_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_done) begin
                    n_state = mmt_pkg::S_IDLE;
                end
            end
            mmt_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = mmt_pkg::S_READ;
                end
            end
            mmt_pkg::S_READ: begin
                n_state = mmt_pkg::S_UPDATE;
            end
            mmt_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = i_status.scan_start ? mmt_pkg::S_SCAN_RD : mmt_pkg::S_DONE;
            end
            mmt_pkg::S_SCAN_RD: begin
                if (i_status.mex_in_bound) begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = mmt_pkg::S_SCAN_CHK;
                end else begin
                    n_state = mmt_pkg::S_DONE;
                end
            end
            mmt_pkg::S_SCAN_CHK: begin
                if (i_status.scan_hit) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = mmt_pkg::S_SCAN_RD;
                end else begin
                    n_state = mmt_pkg::S_DONE;
                end
            end
            mmt_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = mmt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mmt_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/mmt_datapath.sv -----
// Count table, mex register, limit register and output register of the tracker.
// Depends on mmt_pkg; driven by commands from mmt_ctrl.
`default_nettype none

module mmt_datapath #(
    parameter int VALUE_SLOTS = mmt_pkg::VALUE_SLOTS_DEFAULT
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [mmt_pkg::LIMIT_W-1:0]     i_cfg_data,
    input  wire                             i_action,
    input  wire  [mmt_pkg::VALUE_W-1:0]     i_item_value,
    input  wire                             i_stall,
    output logic                            o_valid,
    output logic [mmt_pkg::MEX_W-1:0]       o_mex,
    output logic                            o_underflow,
    input  mmt_pkg::t_cmd                   i_cmd,
    output mmt_pkg::t_status                o_status
);

    localparam int ADDR_W = $clog2(VALUE_SLOTS);
    localparam logic [16:0]       SlotMax  = 17'(VALUE_SLOTS - 1);
    localparam logic [ADDR_W-1:0] LastAddr = ADDR_W'(VALUE_SLOTS - 1);

    logic [mmt_pkg::COUNT_W-1:0] r_counts [VALUE_SLOTS];
    logic [mmt_pkg::COUNT_W-1:0] r_rd_data;
    logic [ADDR_W-1:0]           r_clr_addr;
    logic [mmt_pkg::LIMIT_W-1:0] r_value_limit;
    logic                        r_action;
    logic [mmt_pkg::VALUE_W-1:0] r_value;
    logic [mmt_pkg::MEX_W-1:0]   r_mex;
    logic                        r_under;
    logic                        r_out_valid;
    logic [mmt_pkg::MEX_W-1:0]   r_out_mex;
    logic                        r_out_under;

    logic [16:0]                 w_lim;
    logic [16:0]                 w_mex17;
    logic                        w_in_range;
    logic                        w_is_insert;
    logic [mmt_pkg::COUNT_W-1:0] w_new_count;
    logic                        w_wr_en;
    logic [ADDR_W-1:0]           w_wr_addr;
    logic [mmt_pkg::COUNT_W-1:0] w_wr_data;
    logic [ADDR_W-1:0]           w_rd_addr;
    logic                        w_rm_hit;
    logic                        w_rm_under;

    // Limit in use: the smaller of the register and the last slot
    always_comb begin
        w_lim   = ({7'b0, r_value_limit} > SlotMax) ? SlotMax : {7'b0, r_value_limit};
        w_mex17 = {6'b0, r_mex};
    end

    assign w_in_range  = {1'b0, r_value} <= w_lim;
    assign w_is_insert = r_action == mmt_pkg::ACT_INSERT;
    assign w_rm_under  = w_in_range && !w_is_insert && (r_rd_data == '0);
    assign w_rm_hit    = w_in_range && !w_is_insert && (r_rd_data != '0);

    always_comb begin
        if (w_is_insert) begin
            w_new_count = (r_rd_data == mmt_pkg::COUNT_MAX) ? r_rd_data
                                                            : r_rd_data + 16'd1;
        end else begin
            w_new_count = r_rd_data - 16'd1;
        end
        if (i_cmd.clear) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_clr_addr;
            w_wr_data = '0;
        end else begin
            w_wr_en   = i_cmd.update && w_in_range && (w_is_insert || w_rm_hit);
            w_wr_addr = r_value[ADDR_W-1:0];
            w_wr_data = w_new_count;
        end
        w_rd_addr = i_cmd.scan_rd ? w_mex17[ADDR_W-1:0] : r_value[ADDR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_counts[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_counts[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr    <= '0;
            r_value_limit <= mmt_pkg::LIMIT_RESET;
            r_mex         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.clear && (r_clr_addr != LastAddr)) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_we) begin
                r_value_limit <= i_cfg_data;
            end
            if (i_cmd.update && o_status.scan_start) begin
                // the inserted slot is nonzero now, so skip past it
                r_mex <= r_mex + 1'b1;
            end else if (i_cmd.update && w_rm_hit && (r_rd_data == 16'd1)
                         && ({1'b0, r_value} < w_mex17)) begin
                r_mex <= r_value[mmt_pkg::MEX_W-1:0];
            end else if (i_cmd.scan_step) begin
                r_mex <= r_mex + 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_action <= i_action;
            r_value  <= i_item_value;
            r_under  <= 1'b0;
        end else if (i_cmd.update) begin
            r_under <= w_rm_under;
        end
        if (i_cmd.load_out) begin
            r_out_mex   <= r_mex;
            r_out_under <= r_under;
        end
    end

    always_comb begin
        o_status.clear_done   = r_clr_addr == LastAddr;
        o_status.scan_start   = w_in_range && w_is_insert && (w_mex17 == {1'b0, r_value});
        o_status.mex_in_bound = w_mex17 <= w_lim;
        o_status.scan_hit     = r_rd_data != '0;
        o_status.out_free     = !r_out_valid || !i_stall;
    end

    assign o_valid     = r_out_valid;
    assign o_mex       = r_out_mex;
    assign o_underflow = r_out_under;

    a_under_only_remove : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out && r_under |-> r_action == mmt_pkg::ACT_REMOVE)
        else $error("underflow reported for an insert");

    a_scan_in_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> o_status.mex_in_bound)
        else $error("scan read above the limit in use");

    a_clear_to_end : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.clear) && !i_cmd.clear |-> $past(o_status.clear_done))
        else $error("clearing sweep ended early");

    a_load_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> o_status.out_free)
        else $error("result loaded over an untaken result");

endmodule

`default_nettype wire

// ----- hdl/multiset_mex_tracker.sv -----
// Multiset mex tracker: top level joining the controller and the datapath.
// Depends on mmt_pkg, mmt_ctrl and mmt_datapath.
//
// Input beats (i_valid / o_stall) carry i_action (insert or remove) and
// i_item_value; a beat is taken when i_valid is high and o_stall is low. Each
// item returns one output beat (o_valid / i_stall): o_mex, the smallest value
// with a zero count after the item, and o_underflow, set when a remove found
// its count already zero. i_cfg_we with i_cfg_data writes value_limit; write
// it only while idle. Values above min(value_limit, VALUE_SLOTS-1) change nothing.
// One item at a time: an accepted item goes through count read, update and
// done, the result then moves into the output register, and the next beat is
// taken only once the controller is back in idle. An insert at the mex walks
// it past each nonzero slot (one count read, one check of the read data per
// slot), stopping at a zero count or at the limit in use plus one.
// Reset is synchronous, active low. The count memory is then swept to zero,
// one slot per cycle, with o_stall high throughout; the limit resets
// to 1023 and the mex to zero.
// While i_stall holds a result in the output register, the next item is still
// accepted and worked on, then holds at its end until the register frees up.
`default_nettype none

module multiset_mex_tracker #(
    parameter int VALUE_SLOTS = mmt_pkg::VALUE_SLOTS_DEFAULT
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [mmt_pkg::LIMIT_W-1:0] i_cfg_data,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire                         i_action,
    input  wire  [mmt_pkg::VALUE_W-1:0] i_item_value,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [mmt_pkg::MEX_W-1:0]   o_mex,
    output logic                        o_underflow
);

    mmt_pkg::t_cmd    w_cmd;
    mmt_pkg::t_status w_status;

    // Sequence each item: read its count, update, walk the mex, hand off
    mmt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Hold the count table, mex, limit and the result register
    mmt_datapath #(
        .VALUE_SLOTS (VALUE_SLOTS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_action     (i_action),
        .i_item_value (i_item_value),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_mex        (o_mex),
        .o_underflow  (o_underflow),
        .i_cmd        (w_cmd),
        .o_status     (w_status)
    );

endmodule

`default_nettype wire
